// ===== hw/rtl/lge_pkg.sv =====
`default_nettype none

package lge_pkg;

  localparam int MAX_SIDE_DEF = 128;
  localparam int SIDE_RESET   = 100;
  localparam int CFG_W        = 8;
  localparam int COORD_W      = 7;
  localparam int LIVE_W       = 15;
  localparam int GEN_W        = 32;

  typedef enum logic [1:0] {
    FUNC_TOGGLE  = 2'd0,
    FUNC_ADVANCE = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
  } in_item_t;

  typedef struct packed {
    logic              cell_alive;
    logic [LIVE_W-1:0] live_count;
    logic [GEN_W-1:0]  generation_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_init;
    logic clr_step;
    logic cell_rd;
    logic cell_upd;
    logic gen_start;
    logic gen_cur;
    logic gen_load;
    logic gen_col;
    logic gen_write;
    logic gen_finish;
    logic report;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic row_last;
    logic col_last;
    logic side_zero;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/life_grid_engine.sv =====
`default_nettype none

// Life grid engine: a square grid of cells under the B3/S23 rule with a dead
// border. Pulse start with an item while busy is low; each item produces
// exactly one result, shown on out_item for a single cycle with out_valid
// high, and the receiver has no way to stall it (a clear item gives none if
// a configuration write restarts its sweep). The grid memory holds one row
// per word, and the next generation is built one cell per clock from a
// three-row window, with one memory write per row; a zero side skips this.
// After reset, and after a write to cfg_wdata while idle or clearing, the
// block sweeps the grid clear with busy high. Busy is also high in the cycle
// of a configuration write, so no item is taken then. Such a configuration
// write also empties the grid and zeroes the live count; it leaves the
// generation count.
module life_grid_engine #(
  parameter int MAX_SIDE = lge_pkg::MAX_SIDE_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire lge_pkg::in_item_t         in_item,
  output logic                           out_valid,
  output lge_pkg::out_item_t             out_item,
  input  wire logic                      cfg_we,
  input  wire logic [lge_pkg::CFG_W-1:0] cfg_wdata
);

  import lge_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lge_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_item.func),
    .cfg_we  (cfg_we),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  lge_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lge_ram.sv =====
`default_nettype none

module lge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lge_ctrl.sv =====
`default_nettype none

module lge_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire lge_pkg::func_t in_func,
  input  wire logic          cfg_we,
  input  wire lge_pkg::stat_t stat,
  output lge_pkg::cmd_t      cmd,
  output logic               busy
);

  import lge_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL_RD,
    S_CELL_UPD,
    S_GEN_START,
    S_GEN_CUR,
    S_GEN_LOAD,
    S_GEN_COL,
    S_GEN_WR,
    S_GEN_DONE,
    S_REPORT
  } state_t;

  state_t state_r, state_nxt;
  logic   report_r, report_nxt;

  always_comb begin
    state_nxt  = state_r;
    report_nxt = report_r;
    cmd        = '0;
    unique case (state_r)
      S_CLEAR: begin
        if (cfg_we) begin
          // A new side during the sweep restarts it and drops any pending report.
          cmd.clr_init = 1'b1;
          report_nxt   = 1'b0;
        end else begin
          cmd.clr_step = 1'b1;
          if (stat.clr_last) begin
            state_nxt = report_r ? S_REPORT : S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (cfg_we) begin
          cmd.clr_init = 1'b1;
          report_nxt   = 1'b0;
          state_nxt    = S_CLEAR;
        end else if (start) begin
          cmd.accept = 1'b1;
          unique case (in_func)
            FUNC_CLEAR: begin
              cmd.clr_init = 1'b1;
              report_nxt   = 1'b1;
              state_nxt    = S_CLEAR;
            end
            FUNC_ADVANCE: state_nxt = S_GEN_START;
            default:      state_nxt = S_CELL_RD;
          endcase
        end
      end
      S_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = S_CELL_UPD;
      end
      S_CELL_UPD: begin
        cmd.cell_upd = 1'b1;
        state_nxt    = S_REPORT;
      end
      S_GEN_START: begin
        if (stat.side_zero) begin
          state_nxt = S_GEN_DONE;
        end else begin
          cmd.gen_start = 1'b1;
          state_nxt     = S_GEN_CUR;
        end
      end
      S_GEN_CUR: begin
        cmd.gen_cur = 1'b1;
        state_nxt   = S_GEN_LOAD;
      end
      S_GEN_LOAD: begin
        cmd.gen_load = 1'b1;
        state_nxt    = S_GEN_COL;
      end
      S_GEN_COL: begin
        cmd.gen_col = 1'b1;
        if (stat.col_last) begin
          state_nxt = S_GEN_WR;
        end
      end
      S_GEN_WR: begin
        cmd.gen_write = 1'b1;
        state_nxt     = stat.row_last ? S_GEN_DONE : S_GEN_LOAD;
      end
      S_GEN_DONE: begin
        cmd.gen_finish = 1'b1;
        state_nxt      = S_REPORT;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        report_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // A configuration write takes the idle cycle, so no item is taken with it.
  assign busy = (state_r != S_IDLE) || cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      report_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      report_r <= report_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lge_dp.sv =====
`default_nettype none

module lge_dp #(
  parameter int MAX_SIDE = lge_pkg::MAX_SIDE_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire lge_pkg::in_item_t         in_item,
  input  wire logic                      cfg_we,
  input  wire logic [lge_pkg::CFG_W-1:0] cfg_wdata,
  input  wire lge_pkg::cmd_t             cmd,
  output lge_pkg::stat_t                 stat,
  output logic                           out_valid,
  output lge_pkg::out_item_t             out_item
);

  import lge_pkg::*;

  localparam int AW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int W1 = SW + 1;
  localparam int CW = ((SW > COORD_W) ? SW : COORD_W) + 1;
  localparam int SIDE_INIT = (SIDE_RESET < MAX_SIDE) ? SIDE_RESET : MAX_SIDE;

  logic [SW-1:0]       side_r;
  logic [AW-1:0]       row_r;
  logic [SW-1:0]       col_r;
  logic [LIVE_W-1:0]   pop_r;
  logic [LIVE_W-1:0]   cnt_r;
  logic [GEN_W-1:0]    gen_r;
  logic                alive_r;
  func_t               func_r;
  logic [COORD_W-1:0]  icol_r;
  logic [COORD_W-1:0]  irow_r;
  logic [MAX_SIDE-1:0] prev_r, cur_r, nxt_r, nrow_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [MAX_SIDE-1:0] ram_wdata, ram_rdata;

  logic                in_range;
  logic                is_toggle;
  logic                cell_bit;
  logic [MAX_SIDE-1:0] flip_mask;
  logic                nxt_row_live;
  logic [MAX_SIDE+1:0] pad_prev, pad_cur, pad_nxt;
  logic [2:0]          win_prev, win_cur, win_nxt;
  logic [3:0]          nbr;
  logic                new_bit;

  lge_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_range  = (CW'(icol_r) < CW'(side_r)) && (CW'(irow_r) < CW'(side_r));
  assign is_toggle = (func_r == FUNC_TOGGLE);
  assign cell_bit  = in_range & ram_rdata[AW'(icol_r)];
  assign flip_mask = MAX_SIDE'(1) << icol_r;

  assign stat.clr_last  = (row_r == AW'(MAX_SIDE - 1));
  assign stat.row_last  = (W1'(row_r) + W1'(1) == W1'(side_r));
  assign stat.col_last  = (W1'(col_r) + W1'(1) == W1'(side_r));
  assign stat.side_zero = (side_r == '0);

  // Rows below the last row in use are real; anything past it counts as dead.
  assign nxt_row_live = (W1'(row_r) + W1'(1) < W1'(side_r));

  // Three-row window with a dead cell padded on each side.
  assign pad_prev = {1'b0, prev_r, 1'b0};
  assign pad_cur  = {1'b0, cur_r, 1'b0};
  assign pad_nxt  = {1'b0, nxt_r, 1'b0};
  assign win_prev = pad_prev[col_r +: 3];
  assign win_cur  = pad_cur[col_r +: 3];
  assign win_nxt  = pad_nxt[col_r +: 3];

  assign nbr = 4'(win_prev[0]) + 4'(win_prev[1]) + 4'(win_prev[2])
             + 4'(win_cur[0]) + 4'(win_cur[2])
             + 4'(win_nxt[0]) + 4'(win_nxt[1]) + 4'(win_nxt[2]);
  assign new_bit = (nbr == 4'd3) || (win_cur[1] && (nbr == 4'd2));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = row_r;
    ram_wdata = nrow_r;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else if (cmd.cell_upd) begin
      ram_we    = is_toggle & in_range;
      ram_waddr = AW'(irow_r);
      ram_wdata = ram_rdata ^ flip_mask;
    end else if (cmd.gen_write) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    ram_raddr = row_r;
    if (cmd.cell_rd) begin
      ram_raddr = AW'(irow_r);
    end else if (cmd.gen_start) begin
      ram_raddr = '0;
    end else if (cmd.gen_cur) begin
      ram_raddr = row_r + AW'(1);
    end else if (cmd.gen_write) begin
      ram_raddr = row_r + AW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= SW'(SIDE_INIT);
      row_r       <= '0;
      pop_r       <= '0;
      gen_r       <= GEN_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.report;
      if (cfg_we) begin
        if (32'(cfg_wdata) >= 32'(MAX_SIDE)) begin
          side_r <= SW'(MAX_SIDE);
        end else begin
          side_r <= SW'(cfg_wdata);
        end
      end
      if (cmd.clr_init) begin
        row_r <= '0;
        pop_r <= '0;
      end else if (cmd.clr_step || cmd.gen_write) begin
        row_r <= row_r + AW'(1);
      end else if (cmd.gen_start) begin
        row_r <= '0;
      end
      if (cmd.cell_upd && is_toggle && in_range) begin
        if (ram_rdata[AW'(icol_r)]) begin
          pop_r <= pop_r - LIVE_W'(1);
        end else begin
          pop_r <= pop_r + LIVE_W'(1);
        end
      end
      if (cmd.gen_finish) begin
        pop_r <= stat.side_zero ? '0 : cnt_r;
        gen_r <= gen_r + GEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r  <= in_item.func;
      icol_r  <= in_item.cell_col;
      irow_r  <= in_item.cell_row;
      alive_r <= 1'b0;
    end
    if (cmd.cell_upd) begin
      alive_r <= is_toggle ? (in_range & ~cell_bit) : cell_bit;
    end
    if (cmd.gen_start) begin
      prev_r <= '0;
      cnt_r  <= '0;
    end
    if (cmd.gen_cur) begin
      cur_r <= ram_rdata;
    end
    if (cmd.gen_load) begin
      nxt_r  <= nxt_row_live ? ram_rdata : '0;
      col_r  <= '0;
      nrow_r <= '0;
    end
    if (cmd.gen_col) begin
      nrow_r[AW'(col_r)] <= new_bit;
      cnt_r              <= cnt_r + LIVE_W'(new_bit);
      col_r              <= col_r + SW'(1);
    end
    if (cmd.gen_write) begin
      prev_r <= cur_r;
      cur_r  <= nxt_r;
    end
    if (cmd.report) begin
      out_item_r.cell_alive       <= alive_r;
      out_item_r.live_count       <= pop_r;
      out_item_r.generation_count <= gen_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
